// ===== hdl/orbb_pkg.sv =====
`timescale 1ns / 1ps
// Package for the overwrite-oldest byte ring buffer.
// Holds sizes, request and status codes, payload structs and controller types.
package orbb_pkg;

  localparam int DEPTH = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = ADDR_W + 1;
  localparam int LOG2_W = 4;
  localparam logic [LOG2_W-1:0] MIN_LOG2 = LOG2_W'(1);
  localparam logic [LOG2_W-1:0] MAX_LOG2 = LOG2_W'(ADDR_W);
  localparam logic [LOG2_W-1:0] SIZE_LOG2_RST = LOG2_W'(12);
  localparam logic [CNT_W-1:0] FULL_LEVEL_RST = CNT_W'(4096);

  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_SKIP  = 3'd3,
    REQ_QUERY = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_TOO_FEW  = 2'd3
  } status_code_t;

  typedef enum logic {
    CFG_SIZE_LOG2  = 1'b0,
    CFG_FULL_LEVEL = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [7:0]       push_byte;
    logic [CNT_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       read_byte;
    logic [CNT_W-1:0] fill_level;
    logic             at_threshold;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic present;
  } cmd_t;

endpackage

// ===== hdl/overwrite_ring_byte_buffer.sv =====
`timescale 1ns / 1ps
// Overwrite-oldest byte ring buffer, top level; uses orbb_pkg, orbb_ctrl, orbb_datapath.
// Timing: an accepted start loads the request in S_IDLE or S_DONE; the controller then passes
// through S_EXEC, which updates the store and result registers, to S_DONE, where done is high.
// A new start is taken in the cycle that presents the previous result; the receiver cannot stall.
// Synchronous reset empties the ring and loads size_log2 = 12 and full_level = 4096.
module overwrite_ring_byte_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  orbb_pkg::req_t             req,
  output logic                       done,
  output orbb_pkg::result_t          result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [orbb_pkg::CNT_W-1:0] cfg_data
);

  orbb_pkg::cmd_t cmd;

  orbb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  orbb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  assign done = cmd.present;

endmodule

// ===== hdl/orbb_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the ring buffer.
// Depends on orbb_pkg for the state and command types.
module orbb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output orbb_pkg::cmd_t cmd
);

  orbb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= orbb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      orbb_pkg::S_IDLE: begin
        if (start) state_next = orbb_pkg::S_EXEC;
      end
      orbb_pkg::S_EXEC: begin
        state_next = orbb_pkg::S_DONE;
      end
      orbb_pkg::S_DONE: begin
        state_next = start ? orbb_pkg::S_EXEC : orbb_pkg::S_IDLE;
      end
      default: state_next = orbb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    cmd = '0;
    unique case (state)
      orbb_pkg::S_IDLE: begin
        cmd.load = start;
      end
      orbb_pkg::S_EXEC: begin
        busy = 1'b1;
        cmd.exec = 1'b1;
      end
      orbb_pkg::S_DONE: begin
        cmd.present = 1'b1;
        cmd.load = start;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

// ===== hdl/orbb_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the ring buffer: configuration, pointers, fill count and byte store.
// Depends on orbb_pkg for sizes, codes and payload structs.
module orbb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  orbb_pkg::cmd_t                cmd,
  input  orbb_pkg::req_t                req,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [orbb_pkg::CNT_W-1:0]    cfg_data,
  output orbb_pkg::result_t             result
);

  logic [7:0] mem [orbb_pkg::DEPTH];
  logic [7:0] mem_q;

  logic [orbb_pkg::LOG2_W-1:0] size_log2;
  logic [orbb_pkg::CNT_W-1:0]  full_level;
  logic [orbb_pkg::ADDR_W-1:0] write_pointer, write_pointer_next;
  logic [orbb_pkg::CNT_W-1:0]  fill_count, fill_count_next;

  orbb_pkg::req_t              req_q;
  logic [1:0]                  status, status_next;
  logic                        rd_ok, rd_ok_next;
  logic                        at_threshold;

  logic [orbb_pkg::LOG2_W-1:0] lg;
  logic [orbb_pkg::CNT_W-1:0]  size;
  logic [orbb_pkg::ADDR_W-1:0] mask;
  logic [orbb_pkg::ADDR_W-1:0] oldest;
  logic [orbb_pkg::ADDR_W-1:0] mem_addr;
  logic                        mem_we;

  always_comb begin
    if (size_log2 < orbb_pkg::MIN_LOG2) begin
      lg = orbb_pkg::MIN_LOG2;
    end else if (size_log2 > orbb_pkg::MAX_LOG2) begin
      lg = orbb_pkg::MAX_LOG2;
    end else begin
      lg = size_log2;
    end
    size = orbb_pkg::CNT_W'(1) << lg;
    mask = orbb_pkg::ADDR_W'(size - orbb_pkg::CNT_W'(1));
    oldest = (write_pointer - fill_count[orbb_pkg::ADDR_W-1:0]) & mask;
  end

  always_comb begin
    write_pointer_next = write_pointer;
    fill_count_next = fill_count;
    status_next = orbb_pkg::ST_OK;
    rd_ok_next = 1'b0;
    mem_we = 1'b0;
    mem_addr = oldest;
    case (req_q.req_type)
      orbb_pkg::REQ_PUSH: begin
        mem_we = 1'b1;
        mem_addr = write_pointer & mask;
        write_pointer_next = (write_pointer + orbb_pkg::ADDR_W'(1)) & mask;
        if (fill_count < size) begin
          fill_count_next = fill_count + orbb_pkg::CNT_W'(1);
        end
      end
      orbb_pkg::REQ_POP: begin
        if (fill_count != '0) begin
          rd_ok_next = 1'b1;
          fill_count_next = fill_count - orbb_pkg::CNT_W'(1);
        end else begin
          status_next = orbb_pkg::ST_EMPTY;
        end
      end
      orbb_pkg::REQ_PEEK: begin
        mem_addr = (oldest + req_q.position[orbb_pkg::ADDR_W-1:0]) & mask;
        if (fill_count > req_q.position) begin
          rd_ok_next = 1'b1;
        end else begin
          status_next = orbb_pkg::ST_RANGE;
        end
      end
      orbb_pkg::REQ_SKIP: begin
        if (req_q.position <= fill_count) begin
          fill_count_next = fill_count - req_q.position;
        end else begin
          status_next = orbb_pkg::ST_TOO_FEW;
        end
      end
      default: begin
        status_next = orbb_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (mem_we) begin
        mem[mem_addr] <= req_q.push_byte;
      end
      mem_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      status <= status_next;
      rd_ok <= rd_ok_next;
      at_threshold <= (fill_count_next >= full_level);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= orbb_pkg::SIZE_LOG2_RST;
      full_level <= orbb_pkg::FULL_LEVEL_RST;
      write_pointer <= '0;
      fill_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        orbb_pkg::CFG_SIZE_LOG2: begin
          size_log2 <= cfg_data[orbb_pkg::LOG2_W-1:0];
          write_pointer <= '0;
          fill_count <= '0;
        end
        orbb_pkg::CFG_FULL_LEVEL: begin
          full_level <= cfg_data;
        end
        default: full_level <= full_level;
      endcase
    end else if (cmd.exec) begin
      write_pointer <= write_pointer_next;
      fill_count <= fill_count_next;
    end
  end

  always_comb begin
    result.status = status;
    result.read_byte = rd_ok ? mem_q : 8'd0;
    result.fill_level = fill_count;
    result.at_threshold = at_threshold;
  end

endmodule

// ===== tb/sv/orbb_checker.sv =====
`timescale 1ns / 1ps
// Checker for the overwrite-oldest byte ring buffer: watches the request, result and
// register write channels, keeps its own ring model and compares every result. Uses orbb_pkg.
module orbb_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  orbb_pkg::req_t             req,
  input  logic                       done,
  input  orbb_pkg::result_t          result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [orbb_pkg::CNT_W-1:0] cfg_data,
  output int                         mismatch_count,
  output int                         results_due
);

  logic [7:0]                  ring_mem [orbb_pkg::DEPTH];
  logic [orbb_pkg::ADDR_W-1:0] wr_ptr;
  logic [orbb_pkg::CNT_W-1:0]  fill;
  logic [orbb_pkg::LOG2_W-1:0] size_lg;
  logic [orbb_pkg::CNT_W-1:0]  level;
  orbb_pkg::result_t           awaited_results [$];
  int                          errors = 0;

  task automatic apply_ring_request(input orbb_pkg::req_t r, output orbb_pkg::result_t res);
    int eff;
    int size;
    int mask;
    int oldest;
    int f;
    int pos;
    eff = int'(size_lg);
    if (eff < int'(orbb_pkg::MIN_LOG2)) eff = int'(orbb_pkg::MIN_LOG2);
    if (eff > int'(orbb_pkg::MAX_LOG2)) eff = int'(orbb_pkg::MAX_LOG2);
    size = 1 << eff;
    mask = size - 1;
    f = int'(fill);
    pos = int'(r.position);
    oldest = (int'(wr_ptr) + size - f) & mask;
    res = '0;
    case (r.req_type)
      orbb_pkg::REQ_PUSH: begin
        ring_mem[int'(wr_ptr) & mask] = r.push_byte;
        wr_ptr = orbb_pkg::ADDR_W'((int'(wr_ptr) + 1) & mask);
        if (f < size) f++;
      end
      orbb_pkg::REQ_POP: begin
        if (f > 0) begin
          res.read_byte = ring_mem[oldest];
          f--;
        end else begin
          res.status = orbb_pkg::ST_EMPTY;
        end
      end
      orbb_pkg::REQ_PEEK: begin
        if (f > pos) res.read_byte = ring_mem[(oldest + pos) & mask];
        else res.status = orbb_pkg::ST_RANGE;
      end
      orbb_pkg::REQ_SKIP: begin
        if (pos <= f) f -= pos;
        else res.status = orbb_pkg::ST_TOO_FEW;
      end
      default: ;
    endcase
    fill = orbb_pkg::CNT_W'(f);
    res.fill_level = fill;
    res.at_threshold = (fill >= level);
  endtask

  always @(posedge clk) begin
    orbb_pkg::result_t want;
    orbb_pkg::result_t fresh;
    if (rst) begin
      size_lg = orbb_pkg::SIZE_LOG2_RST;
      level = orbb_pkg::FULL_LEVEL_RST;
      wr_ptr = '0;
      fill = '0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == orbb_pkg::CFG_SIZE_LOG2) begin
          size_lg = cfg_data[orbb_pkg::LOG2_W-1:0];
          wr_ptr = '0;
          fill = '0;
        end else begin
          level = cfg_data;
        end
      end
      if (done) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no transaction pending: %s%0d %s%02h %s%0d %s%0b",
                     $time, "status=", result.status, "byte=", result.read_byte,
                     "fill=", result.fill_level, "thr=", result.at_threshold);
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status || result.read_byte !== want.read_byte ||
              result.fill_level !== want.fill_level ||
              result.at_threshold !== want.at_threshold) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp status=%0d byte=%02h fill=%0d thr=%0b, %s%0d %s%02h %s%0d %s%0b",
                       $time, want.status, want.read_byte, want.fill_level,
                       want.at_threshold, "got status=", result.status,
                       "byte=", result.read_byte, "fill=", result.fill_level,
                       "thr=", result.at_threshold);
          end
        end
      end
      if (start && !busy) begin
        apply_ring_request(req, fresh);
        awaited_results.push_back(fresh);
      end
    end
    mismatch_count <= errors;
    results_due <= awaited_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the ring buffer testbench: clock, reset, register writes and request stimulus.
// Depends on orbb_pkg, overwrite_ring_byte_buffer and orbb_checker, which does all checking.
module tb_top;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  orbb_pkg::req_t             req = '0;
  logic                       done;
  orbb_pkg::result_t          result;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [orbb_pkg::CNT_W-1:0] cfg_data = '0;
  int                         mismatch_count;
  int                         results_due;
  bit                         idle_en = 1'b1;
  int                         ring_size = 4096;

  overwrite_ring_byte_buffer u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  orbb_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req            (req),
    .done           (done),
    .result         (result),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int size_of(input logic [orbb_pkg::LOG2_W-1:0] lg);
    int eff;
    eff = int'(lg);
    if (eff < int'(orbb_pkg::MIN_LOG2)) eff = int'(orbb_pkg::MIN_LOG2);
    if (eff > int'(orbb_pkg::MAX_LOG2)) eff = int'(orbb_pkg::MAX_LOG2);
    return 1 << eff;
  endfunction

  task automatic send(input logic [2:0] code, input logic [7:0] data,
                      input logic [orbb_pkg::CNT_W-1:0] pos);
    orbb_pkg::req_t r;
    while (idle_en && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    r.req_type = code;
    r.push_byte = data;
    r.position = pos;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input orbb_pkg::cfg_index_t idx,
                         input logic [orbb_pkg::CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == orbb_pkg::CFG_SIZE_LOG2) ring_size = size_of(value[orbb_pkg::LOG2_W-1:0]);
  endtask

  task automatic random_request(input int push_weight);
    int pick;
    logic [orbb_pkg::CNT_W-1:0] pos;
    pos = ($urandom_range(9) == 0) ? orbb_pkg::CNT_W'($urandom_range(8191))
                                   : orbb_pkg::CNT_W'($urandom_range(ring_size + 1));
    pick = $urandom_range(99);
    if (pick < push_weight) begin
      send(orbb_pkg::REQ_PUSH, 8'($urandom_range(255)),
           orbb_pkg::CNT_W'($urandom_range(8191)));
    end else begin
      pick = $urandom_range(19);
      if (pick <= 5)
        send(orbb_pkg::REQ_POP, 8'($urandom_range(255)),
             orbb_pkg::CNT_W'($urandom_range(8191)));
      else if (pick <= 10)
        send(orbb_pkg::REQ_PEEK, 8'($urandom_range(255)), pos);
      else if (pick <= 14)
        send(orbb_pkg::REQ_SKIP, 8'($urandom_range(255)),
             ($urandom_range(9) < 7) ? orbb_pkg::CNT_W'($urandom_range(3)) : pos);
      else if (pick <= 17)
        send(orbb_pkg::REQ_QUERY, 8'($urandom_range(255)),
             orbb_pkg::CNT_W'($urandom_range(8191)));
      else
        send(3'($urandom_range(5, 7)), 8'($urandom_range(255)),
             orbb_pkg::CNT_W'($urandom_range(8191)));
    end
  endtask

  initial begin
    int n_items;
    int push_weight;
    int pick;
    logic [orbb_pkg::LOG2_W-1:0] lg;
    logic [orbb_pkg::CNT_W-1:0] value;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(orbb_pkg::REQ_QUERY, 8'h00, 13'd0);
    send(orbb_pkg::REQ_POP, 8'h00, 13'd0);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd0);
    send(orbb_pkg::REQ_SKIP, 8'h00, 13'd0);
    send(orbb_pkg::REQ_SKIP, 8'h00, 13'd1);
    send(orbb_pkg::REQ_PUSH, 8'h00, 13'd0);
    send(orbb_pkg::REQ_PUSH, 8'hFF, 13'h1FFF);
    send(orbb_pkg::REQ_PUSH, 8'hA5, 13'd0);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd0);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd2);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd3);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'h1FFF);
    send(orbb_pkg::REQ_POP, 8'h00, 13'd0);
    send(orbb_pkg::REQ_SKIP, 8'h00, 13'h1FFF);
    send(orbb_pkg::REQ_SKIP, 8'h00, 13'd1);
    send(3'd5, 8'hFF, 13'h1FFF);
    send(3'd6, 8'h00, 13'd0);
    send(3'd7, 8'h5A, 13'd4096);
    drain();

    // Size zero clamps to a two-byte ring; threshold zero keeps the flag set.
    set_reg(orbb_pkg::CFG_SIZE_LOG2, 13'd0);
    set_reg(orbb_pkg::CFG_FULL_LEVEL, 13'd0);
    cfg_we <= 1'b0;
    send(orbb_pkg::REQ_PUSH, 8'h11, 13'd0);
    send(orbb_pkg::REQ_PUSH, 8'h22, 13'd0);
    send(orbb_pkg::REQ_PUSH, 8'h33, 13'd0);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd1);
    send(orbb_pkg::REQ_POP, 8'h00, 13'd0);
    send(orbb_pkg::REQ_POP, 8'h00, 13'd0);
    send(orbb_pkg::REQ_POP, 8'h00, 13'd0);
    drain();

    // Oversized setting clamps to the full store; fill a good part of it.
    set_reg(orbb_pkg::CFG_SIZE_LOG2, 13'h1FFF);
    set_reg(orbb_pkg::CFG_FULL_LEVEL, 13'd4096);
    cfg_we <= 1'b0;
    for (int i = 0; i < 600; i++) begin
      send(orbb_pkg::REQ_PUSH, 8'($urandom_range(255)),
           orbb_pkg::CNT_W'($urandom_range(8191)));
      if (i == 300) drain();
    end
    send(orbb_pkg::REQ_QUERY, 8'h00, 13'd0);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd599);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd600);
    send(orbb_pkg::REQ_PEEK, 8'h00, 13'd0);
    send(orbb_pkg::REQ_SKIP, 8'h00, 13'd601);
    send(orbb_pkg::REQ_SKIP, 8'h00, 13'd600);
    send(orbb_pkg::REQ_POP, 8'h00, 13'd0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      pick = $urandom_range(99);
      if (pick < 60) lg = orbb_pkg::LOG2_W'($urandom_range(1, 4));
      else if (pick < 80) lg = orbb_pkg::LOG2_W'($urandom_range(5, 8));
      else if (pick < 88) lg = '0;
      else lg = orbb_pkg::LOG2_W'($urandom_range(9, 15));
      value = orbb_pkg::CNT_W'(lg);
      if ($urandom_range(3) == 0)
        value[orbb_pkg::CNT_W-1:orbb_pkg::LOG2_W] =
          (orbb_pkg::CNT_W-orbb_pkg::LOG2_W)'($urandom);
      if (ph == 0 || $urandom_range(3) != 0) set_reg(orbb_pkg::CFG_SIZE_LOG2, value);
      pick = $urandom_range(9);
      if (pick == 0) value = '0;
      else if (pick == 1) value = 13'h1FFF;
      else if (pick == 2) value = orbb_pkg::CNT_W'($urandom_range(8191));
      else value = orbb_pkg::CNT_W'($urandom_range(ring_size + 1));
      set_reg(orbb_pkg::CFG_FULL_LEVEL, value);
      cfg_we <= 1'b0;

      idle_en = (ph % 5 != 2);
      n_items = $urandom_range(60, 110);
      for (int i = 0; i < n_items; i++) begin
        if (i % 40 == 0) begin
          pick = $urandom_range(2);
          push_weight = (pick == 0) ? 25 : (pick == 1) ? 50 : 75;
        end
        random_request(push_weight);
        if ($urandom_range(99) == 0 || (ph == 0 && i == n_items / 2)) drain();
      end
      drain();
    end

    idle_en = 1'b1;
    drain();
    if (mismatch_count == 0 && results_due == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/orbb_pkg.sv
hdl/orbb_ctrl.sv
hdl/orbb_datapath.sv
hdl/overwrite_ring_byte_buffer.sv
tb/sv/orbb_checker.sv
tb/sv/tb_top.sv
